### src/lcgr_pkg.sv
package lcgr_pkg;

  localparam logic [63:0] LCG_MULT = 64'h0000_0005_DEEC_E66D;
  localparam logic [63:0] LCG_ADD = 64'd11;
  localparam logic [63:0] HASH_X = 64'd3129871;
  localparam logic [63:0] HASH_Z = 64'd116129781;
  localparam logic [63:0] HASH_SQ = 64'd42317861;
  localparam logic [63:0] HASH_LIN = 64'hB;
  localparam int unsigned DBL_SHIFT = 27;

  localparam logic [2:0] CMD_SEED = 3'd0;
  localparam logic [2:0] CMD_RAW = 3'd1;
  localparam logic [2:0] CMD_BOUND = 3'd2;
  localparam logic [2:0] CMD_LONG = 3'd3;
  localparam logic [2:0] CMD_DBL = 3'd4;
  localparam logic [2:0] CMD_POS = 3'd5;

  typedef struct packed {
    logic       go;
    logic [1:0] last_dig;
  } mac_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

endpackage

### src/lcg48_random_generator_top.sv
// 48-bit linear congruential generator, one command per item.
// Input channel in_valid/in_ready carries cmd and its operands; the result
// channel out_valid/out_ready carries value and bad_bound, one result per item.
// The block takes one item at a time: in_ready is high only while idle.
// All multiplies go through one shared 64x16 multiply-accumulate unit that
// handles one 16-bit digit of the second operand per cycle; a state advance
// is three digits, covering the 48-bit multiplier.
// Seed, unused codes and bad bounds go straight to the result; a raw draw,
// long and double mantissa advance the state; a power-of-two bound adds a
// multiply by the bound, other bounds a bit-serial remainder unit with a
// redraw on each rejection; position reseed is a chain of multiplies.
// Reset sets the state to the scrambled zero seed 0x5DEECE66D and leaves the
// block idle with no result pending.
// A finished result sits in the output register until out_ready; while the
// receiver stalls no new item is taken.
module lcg48_random_generator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_cmd,
  input  logic signed [63:0] in_seed_value,
  input  logic [5:0]         in_bit_count,
  input  logic signed [31:0] in_bound,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_value,
  output logic               out_bad_bound
);
  import lcgr_pkg::*;

  state_t      st_r, st_nxt;
  logic [47:0] lcg_r, lcg_nxt;
  logic [2:0]  cmd_r;
  logic [5:0]  n_r;
  logic [31:0] bnd_r, py_r, pz_r;
  logic [2:0]  ph_r, ph_nxt;
  logic [63:0] hold_r, hold_nxt, aux_r, aux_nxt;
  logic [63:0] val_r, val_nxt;
  logic        bad_r, bad_nxt;

  mac_ctrl_t   mctl;
  logic [63:0] ma, mb, minit, mres;
  logic        mdone;
  logic        dgo, ddone;
  logic [30:0] dnum, drem;

  logic [5:0]  n_eff;
  logic [31:0] rawsh, chk, b_in;
  logic        pow2, b_bad;
  logic [63:0] s_mix, s_sh;

  lcgr_mac u_mac (
    .clk(clk), .rst_n(rst_n), .ctrl(mctl), .a(ma), .b(mb), .init(minit),
    .done(mdone), .res(mres)
  );

  lcgr_div u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .num(dnum), .den(bnd_r[30:0]),
    .done(ddone), .rem(drem)
  );

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_value = val_r;
  assign out_bad_bound = bad_r;

  assign b_in = in_bound;
  assign b_bad = (b_in == 32'd0) || b_in[31];
  assign pow2 = ((bnd_r & (bnd_r - 32'd1)) == 32'd0);
  assign n_eff = (n_r == 6'd0) ? 6'd1 : ((n_r > 6'd32) ? 6'd32 : n_r);
  assign rawsh = mres[47:16] >> (6'd32 - n_eff);
  assign chk = hold_r[31:0] - {1'b0, drem} + (bnd_r - 32'd1);
  assign s_mix = hold_r ^ mres ^ {{32{py_r[31]}}, py_r};
  assign s_sh = {{16{mres[63]}}, mres[63:16]};
  assign dnum = mres[47:17];

  always_comb begin
    st_nxt = st_r;
    lcg_nxt = lcg_r;
    ph_nxt = ph_r;
    hold_nxt = hold_r;
    aux_nxt = aux_r;
    val_nxt = val_r;
    bad_nxt = bad_r;
    mctl = '0;
    ma = {16'd0, lcg_r};
    mb = LCG_MULT;
    minit = LCG_ADD;
    dgo = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt = 64'd0;
          bad_nxt = 1'b0;
          ph_nxt = 3'd0;
          st_nxt = S_MUL;
          priority if (in_cmd == CMD_SEED) begin
            lcg_nxt = in_seed_value[47:0] ^ LCG_MULT[47:0];
            st_nxt = S_OUT;
          end else if (in_cmd == CMD_BOUND && b_bad) begin
            bad_nxt = 1'b1;
            st_nxt = S_OUT;
          end else if (in_cmd == CMD_POS) begin
            mctl = '{go: 1'b1, last_dig: 2'd1};
            ma = {32'd0, in_pos_x};
            mb = HASH_X;
            minit = 64'd0;
          end else if (in_cmd == CMD_RAW || in_cmd == CMD_BOUND ||
                       in_cmd == CMD_LONG || in_cmd == CMD_DBL) begin
            mctl = '{go: 1'b1, last_dig: 2'd2};
          end else begin
            st_nxt = S_OUT;
          end
        end
      end
      S_MUL: begin
        if (mdone) begin
          priority if (cmd_r == CMD_RAW) begin
            lcg_nxt = mres[47:0];
            val_nxt = {{32{rawsh[31]}}, rawsh};
            st_nxt = S_OUT;
          end else if (cmd_r == CMD_BOUND) begin
            if (ph_r == 3'd0) begin
              lcg_nxt = mres[47:0];
              hold_nxt = {33'd0, mres[47:17]};
              if (pow2) begin
                mctl = '{go: 1'b1, last_dig: 2'd1};
                ma = {33'd0, mres[47:17]};
                mb = {32'd0, bnd_r};
                minit = 64'd0;
                ph_nxt = 3'd1;
              end else begin
                dgo = 1'b1;
                st_nxt = S_DIV;
              end
            end else begin
              val_nxt = {32'd0, mres[62:31]};
              st_nxt = S_OUT;
            end
          end else if (cmd_r == CMD_LONG || cmd_r == CMD_DBL) begin
            lcg_nxt = mres[47:0];
            if (ph_r == 3'd0) begin
              hold_nxt = {32'd0, mres[47:16]};
              mctl = '{go: 1'b1, last_dig: 2'd2};
              ma = {16'd0, mres[47:0]};
              ph_nxt = 3'd1;
            end else begin
              if (cmd_r == CMD_LONG)
                val_nxt = {hold_r[31:0], 32'd0} + {{32{mres[47]}}, mres[47:16]};
              else
                val_nxt = ({38'd0, hold_r[31:6]} << DBL_SHIFT) + {37'd0, mres[47:21]};
              st_nxt = S_OUT;
            end
          end else begin
            // position reseed chain
            unique case (ph_r)
              3'd0: begin
                hold_nxt = {{32{mres[31]}}, mres[31:0]};
                mctl = '{go: 1'b1, last_dig: 2'd1};
                ma = {{32{pz_r[31]}}, pz_r};
                mb = HASH_Z;
                minit = 64'd0;
                ph_nxt = 3'd1;
              end
              3'd1: begin
                hold_nxt = s_mix;
                mctl = '{go: 1'b1, last_dig: 2'd0};
                ma = s_mix;
                mb = HASH_LIN;
                minit = 64'd0;
                ph_nxt = 3'd2;
              end
              3'd2: begin
                aux_nxt = mres;
                mctl = '{go: 1'b1, last_dig: 2'd3};
                ma = hold_r;
                mb = hold_r;
                minit = 64'd0;
                ph_nxt = 3'd3;
              end
              3'd3: begin
                mctl = '{go: 1'b1, last_dig: 2'd1};
                ma = mres;
                mb = HASH_SQ;
                minit = aux_r;
                ph_nxt = 3'd4;
              end
              default: begin
                lcg_nxt = s_sh[47:0] ^ lcg_r ^ LCG_MULT[47:0];
                val_nxt = {16'd0, s_sh[47:0] ^ lcg_r ^ LCG_MULT[47:0]};
                st_nxt = S_OUT;
              end
            endcase
          end
        end
      end
      S_DIV: begin
        if (ddone) begin
          if (chk[31]) begin
            // reject and redraw
            mctl = '{go: 1'b1, last_dig: 2'd2};
            ph_nxt = 3'd0;
            st_nxt = S_MUL;
          end else begin
            val_nxt = {33'd0, drem};
            st_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      lcg_r <= LCG_MULT[47:0];
      ph_r <= 3'd0;
    end else begin
      st_r <= st_nxt;
      lcg_r <= lcg_nxt;
      ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
      n_r <= in_bit_count;
      bnd_r <= in_bound;
      py_r <= in_pos_y;
      pz_r <= in_pos_z;
    end
    hold_r <= hold_nxt;
    aux_r <= aux_nxt;
    val_r <= val_nxt;
    bad_r <= bad_nxt;
  end

`ifndef NO_ASSERTIONS
  a_mac_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mdone |-> st_r == S_MUL)
    else $error("multiply result outside multiply wait");
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    ddone |-> st_r == S_DIV)
    else $error("remainder result outside divide wait");
  a_bad_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_bound |-> out_value == 64'd0)
    else $error("bad bound with nonzero value");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result dropped while stalled");
`endif
endmodule

### src/lcgr_mac.sv
module lcgr_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  lcgr_pkg::mac_ctrl_t ctrl,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  input  logic [63:0]       init,
  output logic              done,
  output logic [63:0]       res
);
  import lcgr_pkg::*;

  logic [63:0] a_r, b_r, acc_r;
  logic [1:0]  k_r, last_r;
  logic        busy_r, done_r;
  logic [15:0] dig;
  logic [79:0] prod;
  logic [63:0] part;

  assign dig = b_r[{k_r, 4'b0} +: 16];
  assign prod = a_r * dig;
  assign part = prod[63:0] << {k_r, 4'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r <= 2'd0;
    end else if (ctrl.go) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      k_r <= 2'd0;
      last_r <= ctrl.last_dig;
      a_r <= a;
      b_r <= b;
      acc_r <= init;
    end else if (busy_r) begin
      acc_r <= acc_r + part;
      k_r <= k_r + 2'd1;
      if (k_r == last_r) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign res = acc_r;

`ifndef NO_ASSERTIONS
  a_not_both: assert property (@(posedge clk) disable iff (!rst_n) !(busy_r && done_r))
    else $error("mac busy and done together");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && !ctrl.go |=> !done_r)
    else $error("mac done held");
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n) ctrl.go |=> busy_r)
    else $error("mac not started");
`endif
endmodule

### src/lcgr_div.sv
module lcgr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [30:0] num,
  input  logic [30:0] den,
  output logic        done,
  output logic [30:0] rem
);
  import lcgr_pkg::*;

  logic [30:0] rem_r, num_r, den_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [31:0] t;

  assign t = {rem_r, num_r[30]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= 5'd0;
    end else if (go) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r <= 5'd0;
      rem_r <= 31'd0;
      num_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      // one quotient bit a cycle, keep only the remainder
      if (t >= {1'b0, den_r}) rem_r <= 31'(t - {1'b0, den_r});
      else rem_r <= t[30:0];
      num_r <= {num_r[29:0], 1'b0};
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd30) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign rem = rem_r;

`ifndef NO_ASSERTIONS
  a_not_both: assert property (@(posedge clk) disable iff (!rst_n) !(busy_r && done_r))
    else $error("div busy and done together");
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n) go |=> busy_r)
    else $error("div not started");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r <= 5'd30)
    else $error("div count overrun");
`endif
endmodule

### verif/tb_lcg48_random_generator_top.sv
`timescale 1ns / 1ps

module tb_lcg48_random_generator_top;
  import lcgr_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_cmd;
  logic signed [63:0] in_seed_value;
  logic [5:0]         in_bit_count;
  logic signed [31:0] in_bound;
  logic signed [31:0] in_pos_x;
  logic signed [31:0] in_pos_y;
  logic signed [31:0] in_pos_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [63:0] out_value;
  logic               out_bad_bound;

  typedef struct packed {
    logic [63:0] value;
    logic        bad_bound;
  } draw_result_t;

  localparam logic [47:0] SEED_SCRAMBLE = 48'h5_DEEC_E66D;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic [47:0]  model_state;
  draw_result_t pending_draws[$];
  int unsigned  error_count;
  int unsigned  items_sent;
  int unsigned  results_seen;
  int unsigned  cycle_count;
  bit           recv_stall_en;
  int unsigned  cmd_hits[8];

  lcg48_random_generator_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_seed_value (in_seed_value),
    .in_bit_count  (in_bit_count),
    .in_bound      (in_bound),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_bad_bound (out_bad_bound)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [63:0] sext32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // Advance the generator and take the top n bits.
  function automatic logic [31:0] next_bits(int unsigned n);
    logic [63:0] prod;
    prod = {16'd0, model_state} * LCG_MULT + LCG_ADD;
    model_state = prod[47:0];
    return 32'(model_state >> (48 - n));
  endfunction

  function automatic draw_result_t predict_draw(logic [2:0] cmd, logic [63:0] seed,
      logic [5:0] nbits, logic [31:0] bnd, logic [31:0] px, logic [31:0] py,
      logic [31:0] pz);
    draw_result_t res;
    int unsigned  n;
    logic [31:0]  r;
    logic [31:0]  rem;
    logic [63:0]  s;
    logic [63:0]  top;
    res = '0;
    case (cmd)
      CMD_SEED: model_state = seed[47:0] ^ SEED_SCRAMBLE;
      CMD_RAW: begin
        n = nbits;
        if (n < 1) n = 1;
        if (n > 32) n = 32;
        res.value = sext32(next_bits(n));
      end
      CMD_BOUND: begin
        if (bnd == 0 || bnd[31]) begin
          res.bad_bound = 1'b1;
        end else if ((bnd & (bnd - 1)) == 0) begin
          res.value = ({32'd0, bnd} * {32'd0, next_bits(31)}) >> 31;
        end else begin
          do begin
            r = next_bits(31);
            rem = r % bnd;
          end while (((r - rem + (bnd - 32'd1)) & 32'h8000_0000) != 0);
          res.value = {32'd0, rem};
        end
      end
      CMD_LONG: begin
        top = sext32(next_bits(32));
        res.value = (top << 32) + sext32(next_bits(32));
      end
      CMD_DBL: begin
        top = {32'd0, next_bits(26)} << DBL_SHIFT;
        res.value = top + {32'd0, next_bits(27)};
      end
      CMD_POS: begin
        s = sext32(32'(px * 32'(HASH_X))) ^ (sext32(pz) * HASH_Z) ^ sext32(py);
        s = s * s * HASH_SQ + s * HASH_LIN;
        s = {{16{s[63]}}, s[63:16]};
        model_state = s[47:0] ^ model_state ^ SEED_SCRAMBLE;
        res.value = {16'd0, model_state};
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("error at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic send_item(logic [2:0] cmd, logic [63:0] seed, logic [5:0] nbits,
      logic [31:0] bnd, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
      bit idle_en);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 16) : 0;
    // drop valid only when idle cycles come before this item
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_seed_value <= seed;
    in_bit_count  <= nbits;
    in_bound      <= bnd;
    in_pos_x      <= px;
    in_pos_y      <= py;
    in_pos_z      <= pz;
    do @(posedge clk); while (!in_ready);
    pending_draws.push_back(predict_draw(cmd, seed, nbits, bnd, px, py, pz));
    cmd_hits[cmd]++;
    items_sent++;
  endtask

  // Receiver: draw a stall per item, then hold ready until the result is taken.
  initial begin
    int unsigned stall;
    draw_result_t want;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = recv_stall_en ? $urandom_range(0, 16) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (pending_draws.size() == 0) begin
        report_mismatch("unexpected result", out_value, 64'd0);
      end else begin
        want = pending_draws.pop_front();
        if (out_value !== want.value) report_mismatch("value", out_value, want.value);
        if (out_bad_bound !== want.bad_bound)
          report_mismatch("bad_bound", {63'd0, out_bad_bound}, {63'd0, want.bad_bound});
      end
    end
  end

  task automatic test_directed_extremes();
    send_item(CMD_RAW, '0, 6'd0, '0, '0, '0, '0, 1'b0);
    send_item(CMD_RAW, '0, 6'd1, '0, '0, '0, '0, 1'b0);
    send_item(CMD_RAW, '0, 6'd32, '0, '0, '0, '0, 1'b0);
    send_item(CMD_RAW, '0, 6'd63, '0, '0, '0, '0, 1'b0);
    send_item(CMD_SEED, 64'h8000_0000_0000_0000, '0, '0, '0, '0, '0, 1'b0);
    send_item(CMD_LONG, '0, '0, '0, '0, '0, '0, 1'b0);
    send_item(CMD_SEED, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0, '0, '0, '0, 1'b0);
    send_item(CMD_DBL, '0, '0, '0, '0, '0, '0, 1'b0);
    send_item(CMD_SEED, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, '0, '0, '0, 1'b0);
    send_item(CMD_BOUND, '0, '0, 32'd0, '0, '0, '0, 1'b0);
    send_item(CMD_BOUND, '0, '0, 32'h8000_0000, '0, '0, '0, 1'b0);
    send_item(CMD_BOUND, '0, '0, 32'hFFFF_FFFF, '0, '0, '0, 1'b0);
    send_item(CMD_BOUND, '0, '0, 32'd1, '0, '0, '0, 1'b0);
    send_item(CMD_BOUND, '0, '0, 32'h4000_0000, '0, '0, '0, 1'b0);
    send_item(CMD_BOUND, '0, '0, 32'h7FFF_FFFF, '0, '0, '0, 1'b0);
    send_item(CMD_BOUND, '0, '0, 32'h6000_0001, '0, '0, '0, 1'b0);
    send_item(CMD_BOUND, '0, '0, 32'd3, '0, '0, '0, 1'b0);
    send_item(CMD_POS, '0, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_POS, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
    send_item(CMD_POS, '0, '0, '0, '0, '0, '0, 1'b0);
    send_item(3'd6, '0, 6'd5, 32'd7, '0, '0, '0, 1'b0);
    send_item(3'd7, '0, 6'd5, 32'd7, '0, '0, '0, 1'b0);
    send_item(CMD_RAW, '0, 6'd17, '0, '0, '0, '0, 1'b0);
  endtask

  task automatic test_random_commands(int unsigned count);
    logic [2:0]  cmd;
    logic [31:0] bnd;
    bit          idle_en;
    for (int i = 0; i < count; i++) begin
      // alternate stretches with and without idling on both sides
      idle_en = ((i / 100) % 3) != 2;
      recv_stall_en = idle_en;
      cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                         : 3'($urandom_range(0, 5));
      case ($urandom_range(0, 4))
        0: bnd = 32'd1 << $urandom_range(0, 31);
        1: bnd = $urandom_range(1, 100);
        2: bnd = 32'h4000_0000 + $urandom_range(1, 32'h3FFF_FFFF);
        default: bnd = $urandom;
      endcase
      send_item(cmd, {$urandom, $urandom}, 6'($urandom), bnd, $urandom, $urandom,
                $urandom, idle_en);
    end
  endtask

  initial begin
    int unsigned settle;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = CMD_SEED;
    in_seed_value = '0;
    in_bit_count  = '0;
    in_bound      = '0;
    in_pos_x      = '0;
    in_pos_y      = '0;
    in_pos_z      = '0;
    error_count   = 0;
    items_sent    = 0;
    results_seen  = 0;
    cycle_count   = 0;
    recv_stall_en = 1'b1;
    model_state   = SEED_SCRAMBLE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_random_commands(1200);
    in_valid <= 1'b0;
    recv_stall_en = 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 200) begin
      @(posedge clk);
      settle++;
    end
    $display("sent %0d items, checked %0d results, %0d errors", items_sent,
             results_seen, error_count);
    $display("per command: seed %0d raw %0d bound %0d long %0d dbl %0d pos %0d unused %0d",
             cmd_hits[0], cmd_hits[1], cmd_hits[2], cmd_hits[3], cmd_hits[4],
             cmd_hits[5], cmd_hits[6] + cmd_hits[7]);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
